@@ hdl/brf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// brf_pkg
// Shared widths, operation codes and defaults for the byte ring fifo with
// peek and skip.
// ----------------------------------------------------------------------------
package brf_pkg;

  localparam int DEPTH_DEFAULT = 1024;

  localparam int FUNC_W   = 3;
  localparam int BYTE_W   = 8;
  localparam int AMOUNT_W = 11;
  localparam int COUNT_W  = 11;
  localparam int CFG_W    = 4;

  // stream beat layouts; tdata padded to whole bytes
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;
  localparam int IN_TUSER_W  = FUNC_W;
  localparam int OUT_TUSER_W = 1;

  localparam logic [CFG_W-1:0] CAP_LOG2_RESET = 4'd10;

  localparam logic [FUNC_W-1:0] FUNC_PUT     = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_POLL    = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_PEEK    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_SKIP    = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_RESERVE = 3'd4;

endpackage
`default_nettype wire

@@ hdl/byte_ring_fifo_peek_skip.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// byte_ring_fifo_peek_skip
// Byte fifo over a power-of-two ring with put, poll, peek, skip and reserve.
// ----------------------------------------------------------------------------
// Each beat on the input stream carries one operation and yields exactly one
// result beat, in order. An operation sits in an input register, where its
// pointer compare and add are worked out and the ring memory is read or
// written; the result is loaded into the output register when the operation
// advances out of the input register. A new operation can be accepted
// every cycle while results are taken; while a result waits, one more
// operation is held in the input register before the input stalls. The ring
// memory has one write port and one registered read port, and needs no
// clearing pass after reset. The user must write capacity in use through
// the cfg channel only while the fifo is idle; the block does not enforce it.
module byte_ring_fifo_peek_skip #(
  parameter int DEPTH = brf_pkg::DEPTH_DEFAULT
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               s_tvalid,
  output logic                              s_tready,
  input  wire  [brf_pkg::IN_TDATA_W-1:0]    s_tdata,   // data_byte, amount
  input  wire  [brf_pkg::IN_TUSER_W-1:0]    s_tuser,   // func
  output logic                              m_tvalid,
  input  wire                               m_tready,
  output logic [brf_pkg::OUT_TDATA_W-1:0]   m_tdata,   // data_out, count_out
  output logic [brf_pkg::OUT_TUSER_W-1:0]   m_tuser,   // ok
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [brf_pkg::CFG_W-1:0]         cfg_data   // capacity_log2
);

  localparam int AW = $clog2(DEPTH);
  localparam int PW = AW + 1;
  localparam int CW = (PW > brf_pkg::AMOUNT_W) ? PW : brf_pkg::AMOUNT_W;
  localparam logic [PW-1:0] CAP_MAX = PW'(DEPTH);

  // configuration and pointers
  logic [brf_pkg::CFG_W-1:0] cap_log2;
  logic [PW-1:0]             head, head_next;
  logic [PW-1:0]             tail, tail_next;

  // input stage
  logic                          s1_valid;
  logic [brf_pkg::FUNC_W-1:0]    s1_func;
  logic [brf_pkg::BYTE_W-1:0]    s1_byte;
  logic [brf_pkg::AMOUNT_W-1:0]  s1_amount;

  // output stage
  logic [brf_pkg::COUNT_W-1:0]   cnt_q;
  logic                          ok_q;
  logic                          rd_en_q;
  logic [brf_pkg::BYTE_W-1:0]    rd_q;

  logic [brf_pkg::BYTE_W-1:0] ring [DEPTH];

  logic          advance;
  logic [PW-1:0] cap, fill, room;
  logic [AW-1:0] cap_mask, rd_addr, wr_addr;
  logic [CW-1:0] amt_w, fill_w, room_w, peek_sum, cnt_w;
  logic          ok, rd_en, wr_en;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready  = !s1_valid || advance;

  always_comb begin
    cap      = (32'(cap_log2) >= AW) ? CAP_MAX : (PW'(1) << cap_log2);
    cap_mask = AW'(cap - PW'(1));
    fill     = head - tail;
    room     = (fill >= cap) ? '0 : (cap - fill);
    amt_w    = CW'(s1_amount);
    fill_w   = CW'(fill);
    room_w   = CW'(room);
    peek_sum = CW'(tail) + amt_w;
    wr_addr  = head[AW-1:0] & cap_mask;
    rd_addr  = tail[AW-1:0] & cap_mask;
    head_next = head;
    tail_next = tail;
    ok    = 1'b0;
    cnt_w = '0;
    rd_en = 1'b0;
    wr_en = 1'b0;
    unique case (s1_func)
      brf_pkg::FUNC_PUT: begin
        if (room != '0) begin
          ok        = 1'b1;
          wr_en     = 1'b1;
          head_next = head + PW'(1);
          cnt_w     = room_w - CW'(1);
        end
      end
      brf_pkg::FUNC_POLL: begin
        if (fill != '0) begin
          ok        = 1'b1;
          rd_en     = 1'b1;
          tail_next = tail + PW'(1);
          cnt_w     = fill_w - CW'(1);
        end
      end
      brf_pkg::FUNC_PEEK: begin
        rd_addr = peek_sum[AW-1:0] & cap_mask;
        if (amt_w < fill_w) begin
          ok    = 1'b1;
          rd_en = 1'b1;
        end
      end
      brf_pkg::FUNC_SKIP: begin
        ok        = 1'b1;
        cnt_w     = (amt_w > fill_w) ? fill_w : amt_w;
        tail_next = tail + cnt_w[PW-1:0];
      end
      brf_pkg::FUNC_RESERVE: begin
        ok        = 1'b1;
        cnt_w     = (amt_w > room_w) ? room_w : amt_w;
        head_next = head + cnt_w[PW-1:0];
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (advance && wr_en) begin
      ring[wr_addr] <= s1_byte;
    end
    if (advance) begin
      rd_q <= ring[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_func   <= s_tuser;
      s1_byte   <= s_tdata[brf_pkg::BYTE_W-1:0];
      s1_amount <= s_tdata[brf_pkg::BYTE_W +: brf_pkg::AMOUNT_W];
    end
    if (advance) begin
      ok_q    <= ok;
      rd_en_q <= rd_en;
      cnt_q   <= cnt_w[brf_pkg::COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_log2 <= brf_pkg::CAP_LOG2_RESET;
      head     <= '0;
      tail     <= '0;
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_log2 <= cfg_data;
      end
      if (advance) begin
        head <= head_next;
        tail <= tail_next;
      end
      if (s_tready) begin
        s1_valid <= s_tvalid;
      end
      if (advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {(brf_pkg::OUT_TDATA_W - brf_pkg::COUNT_W - brf_pkg::BYTE_W)'(0),
                    cnt_q, (rd_en_q ? rd_q : brf_pkg::BYTE_W'(0))};
  assign m_tuser = ok_q;

endmodule
`default_nettype wire

@@ hdl/brf_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// brf_checker
// Port-level checks for the byte ring fifo, bound to the top level.
// ----------------------------------------------------------------------------
module brf_checker (
  input wire                              clk,
  input wire                              rst,
  input wire                              s_tvalid,
  input wire                              s_tready,
  input wire                              m_tvalid,
  input wire                              m_tready,
  input wire [brf_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input wire [brf_pkg::OUT_TUSER_W-1:0]   m_tuser
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // input side only stalls behind a waiting result
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output backpressure");

  // a rising result valid traces back to an accepted input beat
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result beat without matching input beat");

  // reset empties the output register
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind byte_ring_fifo_peek_skip brf_checker u_brf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the byte ring fifo with peek, skip and reserve.
// A behavioural copy of the ring (pointers, store, capacity) is advanced on
// every accepted operation beat and the expected result is queued; the
// result stream is compared field by field against that queue. Directed
// corner cases come first, then random traffic over a sweep of capacities,
// with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module testbench;

  localparam int RING_SLOTS = brf_pkg::DEPTH_DEFAULT;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [brf_pkg::FUNC_W-1:0] FUNC_FIRST_UNUSED = brf_pkg::FUNC_RESERVE + 3'd1;

  typedef struct packed {
    logic                         ok;
    logic [brf_pkg::BYTE_W-1:0]   data_out;
    logic [brf_pkg::COUNT_W-1:0]  count_out;
  } ring_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [brf_pkg::IN_TDATA_W-1:0] s_tdata = '0;   // data_byte, amount
  logic [brf_pkg::IN_TUSER_W-1:0] s_tuser = '0;   // func
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [brf_pkg::OUT_TDATA_W-1:0] m_tdata;       // data_out, count_out
  logic [brf_pkg::OUT_TUSER_W-1:0] m_tuser;       // ok
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [brf_pkg::CFG_W-1:0] cfg_data = '0;       // capacity_log2

  byte_ring_fifo_peek_skip dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // ring copy
  logic [brf_pkg::BYTE_W-1:0]   ring_mem [RING_SLOTS];
  bit                           slot_written [RING_SLOTS];
  logic [brf_pkg::COUNT_W-1:0]  head_ptr = '0;
  logic [brf_pkg::COUNT_W-1:0]  tail_ptr = '0;
  logic [brf_pkg::CFG_W-1:0]    cap_log2 = brf_pkg::CAP_LOG2_RESET;

  ring_result_t result_q [$];
  int mismatches = 0;
  int cycles = 0;
  bit calm = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int cap_size();
    return (cap_log2 >= 4'd10) ? RING_SLOTS : (1 << cap_log2);
  endfunction

  function automatic int fill_level();
    logic [brf_pkg::COUNT_W-1:0] f;
    f = head_ptr - tail_ptr;
    return int'(f);
  endfunction

  function automatic int room_left();
    return (fill_level() >= cap_size()) ? 0 : cap_size() - fill_level();
  endfunction

  function automatic int slot_of(logic [brf_pkg::COUNT_W-1:0] p);
    return int'(p) & (cap_size() - 1);
  endfunction

  function automatic ring_result_t ring_apply(logic [brf_pkg::FUNC_W-1:0] func,
                                              logic [brf_pkg::BYTE_W-1:0] din,
                                              logic [brf_pkg::AMOUNT_W-1:0] amt);
    ring_result_t res;
    int fill;
    int moved;
    res = '0;
    fill = fill_level();
    case (func)
      brf_pkg::FUNC_PUT: begin
        if (room_left() != 0) begin
          ring_mem[slot_of(head_ptr)] = din;
          slot_written[slot_of(head_ptr)] = 1'b1;
          head_ptr = head_ptr + 1'b1;
          res.ok = 1'b1;
          res.count_out = brf_pkg::COUNT_W'(room_left());
        end
      end
      brf_pkg::FUNC_POLL: begin
        if (fill != 0) begin
          res.data_out = ring_mem[slot_of(tail_ptr)];
          tail_ptr = tail_ptr + 1'b1;
          res.ok = 1'b1;
          res.count_out = brf_pkg::COUNT_W'(fill_level());
        end
      end
      brf_pkg::FUNC_PEEK: begin
        if (int'(amt) < fill) begin
          res.data_out = ring_mem[slot_of(tail_ptr + amt)];
          res.ok = 1'b1;
        end
      end
      brf_pkg::FUNC_SKIP: begin
        moved = (int'(amt) > fill) ? fill : int'(amt);
        tail_ptr = tail_ptr + brf_pkg::COUNT_W'(moved);
        res.ok = 1'b1;
        res.count_out = brf_pkg::COUNT_W'(moved);
      end
      brf_pkg::FUNC_RESERVE: begin
        moved = (int'(amt) > room_left()) ? room_left() : int'(amt);
        head_ptr = head_ptr + brf_pkg::COUNT_W'(moved);
        res.ok = 1'b1;
        res.count_out = brf_pkg::COUNT_W'(moved);
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // result side stalls
  int stall_left = 0;
  always @(posedge clk) begin
    int r;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (calm || r < 70) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        stall_left <= (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
      end
    end
  end

  task automatic note_mismatch(string what, ring_result_t exp_r, ring_result_t got_r);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] %s: expected ok=%0d data=%02h count=%0d, got ok=%0d data=%02h count=%0d",
               $realtime, what, exp_r.ok, exp_r.data_out, exp_r.count_out,
               got_r.ok, got_r.data_out, got_r.count_out);
  endtask

  always @(posedge clk) begin
    ring_result_t got_r;
    ring_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      got_r.ok = m_tuser[0];
      got_r.data_out = m_tdata[brf_pkg::BYTE_W-1:0];
      got_r.count_out = m_tdata[brf_pkg::BYTE_W +: brf_pkg::COUNT_W];
      if (result_q.size() == 0) begin
        note_mismatch("unexpected beat", '0, got_r);
      end else begin
        exp_r = result_q.pop_front();
        if (got_r.ok !== exp_r.ok || got_r.data_out !== exp_r.data_out ||
            got_r.count_out !== exp_r.count_out)
          note_mismatch("result mismatch", exp_r, got_r);
      end
    end
  end

  task automatic send_op(logic [brf_pkg::FUNC_W-1:0] func, logic [brf_pkg::BYTE_W-1:0] din,
                         logic [brf_pkg::AMOUNT_W-1:0] amt);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= func;
    s_tdata <= brf_pkg::IN_TDATA_W'({amt, din});
    do @(posedge clk); while (!s_tready);
    result_q.push_back(ring_apply(func, din, amt));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [brf_pkg::CFG_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_log2 = value;
  endtask

  task automatic test_empty_and_full();
    send_op(brf_pkg::FUNC_POLL, 8'h3C, 11'd0);
    send_op(brf_pkg::FUNC_PEEK, 8'h00, 11'd0);
    send_op(brf_pkg::FUNC_SKIP, 8'h00, 11'd5);
    send_op(brf_pkg::FUNC_PUT, 8'h00, 11'd0);
    send_op(brf_pkg::FUNC_PUT, 8'hFF, 11'h7FF);
    send_op(brf_pkg::FUNC_PEEK, 8'h00, 11'd1);
    send_op(brf_pkg::FUNC_PEEK, 8'h00, 11'd2);
    send_op(brf_pkg::FUNC_POLL, 8'h00, 11'd0);
    send_op(brf_pkg::FUNC_POLL, 8'h00, 11'd0);
    send_op(brf_pkg::FUNC_POLL, 8'h00, 11'd0);
    for (int f = FUNC_FIRST_UNUSED; f < (1 << brf_pkg::FUNC_W); f++)
      send_op(brf_pkg::FUNC_W'(f), 8'hFF, 11'h7FF);
    send_op(brf_pkg::FUNC_RESERVE, 8'h00, 11'h7FF);
    send_op(brf_pkg::FUNC_PUT, 8'h5A, 11'd0);
    send_op(brf_pkg::FUNC_SKIP, 8'h00, 11'h7FF);
  endtask

  task automatic test_single_slot();
    write_capacity(4'd0);
    send_op(brf_pkg::FUNC_PUT, 8'hA5, 11'd0);
    send_op(brf_pkg::FUNC_PUT, 8'h11, 11'd0);
    send_op(brf_pkg::FUNC_PEEK, 8'h00, 11'd0);
    send_op(brf_pkg::FUNC_POLL, 8'h00, 11'd0);
    send_op(brf_pkg::FUNC_RESERVE, 8'h00, 11'h7FF);
    send_op(brf_pkg::FUNC_PEEK, 8'h00, 11'd0);
    send_op(brf_pkg::FUNC_SKIP, 8'h00, 11'h7FF);
  endtask

  task automatic test_capacity_below_fill();
    write_capacity(4'd2);
    for (int i = 0; i < 4; i++) send_op(brf_pkg::FUNC_PUT, 8'(8'h80 + i), 11'd0);
    write_capacity(4'd1);
    send_op(brf_pkg::FUNC_PUT, 8'h77, 11'd0);
    send_op(brf_pkg::FUNC_PEEK, 8'h00, 11'd3);
    send_op(brf_pkg::FUNC_POLL, 8'h00, 11'd0);
    send_op(brf_pkg::FUNC_SKIP, 8'h00, 11'h7FF);
  endtask

  task automatic random_ops(int count, bit pause_midway);
    int sent;
    int r;
    int fill;
    logic [brf_pkg::FUNC_W-1:0] func;
    logic [brf_pkg::AMOUNT_W-1:0] amt;
    sent = 0;
    while (sent < count) begin
      if (pause_midway && sent == count / 2) wait_drained();
      fill = fill_level();
      r = $urandom_range(0, 99);
      amt = brf_pkg::AMOUNT_W'($urandom_range(0, 2047));
      if (r < 4) begin
        func = brf_pkg::FUNC_W'($urandom_range(int'(FUNC_FIRST_UNUSED),
                                               (1 << brf_pkg::FUNC_W) - 1));
      end else if (r < 40) begin
        func = brf_pkg::FUNC_PUT;
      end else if (r < 62) begin
        func = brf_pkg::FUNC_POLL;
        if (fill != 0 && !slot_written[slot_of(tail_ptr)]) begin
          func = brf_pkg::FUNC_SKIP;
          amt = 11'd1;
        end
      end else if (r < 77) begin
        func = brf_pkg::FUNC_PEEK;
        if ($urandom_range(0, 4) != 0) amt = brf_pkg::AMOUNT_W'($urandom_range(0, fill));
        if (int'(amt) < fill && !slot_written[slot_of(tail_ptr + amt)]) begin
          func = brf_pkg::FUNC_SKIP;
          amt = 11'd1;
        end
      end else begin
        func = (r < 88) ? brf_pkg::FUNC_SKIP : brf_pkg::FUNC_RESERVE;
        r = $urandom_range(0, 9);
        if (r < 5) amt = brf_pkg::AMOUNT_W'($urandom_range(0, 4));
        else if (r < 8) amt = brf_pkg::AMOUNT_W'($urandom_range(0, cap_size() + 2));
      end
      send_op(func, 8'($urandom_range(0, 255)), amt);
      if (func <= brf_pkg::FUNC_RESERVE) sent++;
    end
  endtask

  task automatic test_random_capacities();
    logic [brf_pkg::CFG_W-1:0] sweep [16] = '{4'd3, 4'd2, 4'd0, 4'd1, 4'd4, 4'd5, 4'd10,
                                              4'd6, 4'd15, 4'd2, 4'd7, 4'd11, 4'd3, 4'd8,
                                              4'd12, 4'd4};
    for (int p = 0; p < 16; p++) begin
      write_capacity(sweep[p]);
      calm = (p % 4 == 3);
      random_ops(40, p % 2 == 1);
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_and_full();
    test_single_slot();
    test_capacity_below_fill();
    test_random_capacities();
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
